// File: src/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Types, constants and round helpers for the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

    localparam int NumDoubleRounds = 10;
    localparam int DrCntW          = 4;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [2:0] REG_KEY01   = 3'd0;
    localparam logic [2:0] REG_KEY23   = 3'd1;
    localparam logic [2:0] REG_KEY45   = 3'd2;
    localparam logic [2:0] REG_KEY67   = 3'd3;
    localparam logic [2:0] REG_NONCE01 = 3'd4;
    localparam logic [2:0] REG_NONCE2  = 3'd5;
    localparam logic [2:0] REG_CTR     = 3'd6;

    typedef struct packed {
        logic [63:0] data_in;
        logic [3:0]  valid_bytes;
        logic        last_item;
    } in_item_t;

    typedef struct packed {
        logic [63:0] data_out;
        logic [3:0]  out_bytes;
        logic        out_last;
    } out_item_t;

    // classified command from front to back
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;   // already capped at 8
        logic        last;
        logic        new_blk;  // generate keystream before use
        logic        new_msg;  // reload counter first
        logic [2:0]  pos;
    } cmd_t;

    typedef logic [15:0][31:0] state_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
        logic [31:0] ta, tb, tc, td;
        ta = a + b; td = rotl(d ^ ta, 16);
        tc = c + td; tb = rotl(b ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        qr = {ta, tb, tc, td};
    endfunction

endpackage

// File: src/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 (RFC 7539) stream encryptor, eight message bytes per transaction.
// ----------------------------------------------------------------------------
//  channel | ports            | payload
//  input   | s_valid/s_ready  | in_item_t  (data_in, valid_bytes, last_item)
//  result  | m_valid/m_ready  | out_item_t (data_out, out_bytes, out_last)
//  config  | cfg_valid/ready  | cfg_index (0..6), cfg_data (64 bits)
//
//  An item inside a keystream block is served from the stored keystream in
//  the back end. The first item of each 64-byte block waits for load, ten
//  double rounds on one shared round unit, and finalize. Reset (aresetn
//  low, synchronous) clears config and control registers, queue, position.
//  A two-entry queue sits between the front and back, and a result register
//  holds output; with m_ready low, input is taken until the queue is full.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cc20_pkg::in_item_t    s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cc20_pkg::out_item_t   m_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data
);
    import cc20_pkg::*;

    logic [255:0] key_reg;
    logic [95:0]  nonce_reg;
    logic [31:0]  ctr_reg;

    cmd_t f_cmd, b_cmd;
    logic f_valid, f_ready, b_valid, b_ready;

    // configuration: writes always taken; unknown indexes ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            nonce_reg <= '0;
            ctr_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY01:   key_reg[63:0]    <= cfg_data;
                REG_KEY23:   key_reg[127:64]  <= cfg_data;
                REG_KEY45:   key_reg[191:128] <= cfg_data;
                REG_KEY67:   key_reg[255:192] <= cfg_data;
                REG_NONCE01: nonce_reg[63:0]  <= cfg_data;
                REG_NONCE2:  nonce_reg[95:64] <= cfg_data[31:0];
                REG_CTR:     ctr_reg          <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    cc20_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    cc20_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
    );

    cc20_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .key(key_reg), .nonce(nonce_reg), .init_ctr(ctr_reg),
        .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );
endmodule

// File: src/cc20_front.sv
// ----------------------------------------------------------------------------
// cc20_front
// Accepts items, tracks message and block position, pushes commands.
// ----------------------------------------------------------------------------
module cc20_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cc20_pkg::in_item_t s_item,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cc20_pkg::cmd_t    cmd
);
    import cc20_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic       started_reg, started_next;
    logic [2:0] cur_pos;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign cur_pos   = started_reg ? pos_reg : 3'd0;

    always_comb begin
        cmd.data    = s_item.data_in;
        cmd.nbytes  = (s_item.valid_bytes > 4'd8) ? 4'd8 : s_item.valid_bytes;
        cmd.last    = s_item.last_item;
        cmd.new_msg = !started_reg;
        cmd.pos     = cur_pos;
        cmd.new_blk = (cur_pos == 3'd0);
        pos_next     = pos_reg;
        started_next = started_reg;
        if (s_valid && s_ready) begin
            pos_next     = cur_pos + 3'd1;
            started_next = !s_item.last_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            started_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            started_reg <= started_next;
        end
    end
endmodule

// File: src/cc20_fifo.sv
// ----------------------------------------------------------------------------
// cc20_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module cc20_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  cc20_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output cc20_pkg::cmd_t rd_data
);
    import cc20_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr_en, rd_en;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end
endmodule

// File: src/cc20_back.sv
// ----------------------------------------------------------------------------
// cc20_back
// Keystream generator (one double round per cycle) and output XOR stage.
// ----------------------------------------------------------------------------
module cc20_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [255:0]      key,
    input  logic [95:0]       nonce,
    input  logic [31:0]       init_ctr,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cc20_pkg::cmd_t    cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output cc20_pkg::out_item_t m_item
);
    import cc20_pkg::*;

    typedef enum logic [1:0] {IDLE, ROUND, FINAL} st_t;

    st_t                st_reg;
    state_t             x_reg, in_reg, x_next;
    logic [DrCntW-1:0]  dr_reg;
    logic [31:0]        ctr_reg;
    logic [63:0]        ks_reg [8];
    logic               ov_reg;
    out_item_t          oi_reg;
    logic               out_free, use_now;
    logic [63:0]        mask, ks_word;
    logic [31:0]        ctr_use;
    state_t             init_st;

    assign out_free  = !ov_reg || m_ready;
    assign use_now   = (st_reg == IDLE) && cmd_valid && !cmd.new_blk && out_free;
    assign cmd_ready = use_now || ((st_reg == FINAL) && out_free);
    assign m_valid   = ov_reg;
    assign m_item    = oi_reg;
    assign ctr_use   = cmd.new_msg ? init_ctr : ctr_reg;

    always_comb begin
        init_st[0] = SIGMA0; init_st[1] = SIGMA1;
        init_st[2] = SIGMA2; init_st[3] = SIGMA3;
        for (int i = 0; i < 8; i++) init_st[4 + i] = key[32*i +: 32];
        init_st[12] = ctr_use;
        init_st[13] = nonce[31:0];
        init_st[14] = nonce[63:32];
        init_st[15] = nonce[95:64];
    end

    // one double round: columns then diagonals
    always_comb begin
        state_t c;
        c = x_reg;
        {c[0], c[4], c[8],  c[12]} = qr(c[0], c[4], c[8],  c[12]);
        {c[1], c[5], c[9],  c[13]} = qr(c[1], c[5], c[9],  c[13]);
        {c[2], c[6], c[10], c[14]} = qr(c[2], c[6], c[10], c[14]);
        {c[3], c[7], c[11], c[15]} = qr(c[3], c[7], c[11], c[15]);
        {c[0], c[5], c[10], c[15]} = qr(c[0], c[5], c[10], c[15]);
        {c[1], c[6], c[11], c[12]} = qr(c[1], c[6], c[11], c[12]);
        {c[2], c[7], c[8],  c[13]} = qr(c[2], c[7], c[8],  c[13]);
        {c[3], c[4], c[9],  c[14]} = qr(c[3], c[4], c[9],  c[14]);
        x_next = c;
    end

    always_comb begin
        mask = '0;
        for (int b = 0; b < 8; b++) mask[8*b +: 8] = (4'(b) < cmd.nbytes) ? 8'hff : 8'h00;
        ks_word = ks_reg[cmd.pos];
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ROUND) x_reg <= x_next;
        if (st_reg == IDLE && cmd_valid && cmd.new_blk) begin
            x_reg  <= init_st;
            in_reg <= init_st;
        end
        if (st_reg == ROUND && dr_reg == DrCntW'(NumDoubleRounds - 1)) begin
            for (int i = 0; i < 8; i++)
                ks_reg[i] <= {x_next[2*i+1] + in_reg[2*i+1], x_next[2*i] + in_reg[2*i]};
        end
        if (cmd_valid && cmd_ready) begin
            oi_reg.data_out  <= (cmd.data ^ ks_word) & mask;
            oi_reg.out_bytes <= cmd.nbytes;
            oi_reg.out_last  <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= IDLE;
            dr_reg  <= '0;
            ctr_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            if (cmd_valid && cmd_ready) ov_reg <= 1'b1;
            else if (m_ready)           ov_reg <= 1'b0;
            case (st_reg)
                IDLE: begin
                    if (cmd_valid && cmd.new_blk) begin
                        ctr_reg <= ctr_use + 32'd1;
                        dr_reg  <= '0;
                        st_reg  <= ROUND;
                    end
                end
                ROUND: begin
                    dr_reg <= dr_reg + DrCntW'(1);
                    if (dr_reg == DrCntW'(NumDoubleRounds - 1)) st_reg <= FINAL;
                end
                FINAL: begin
                    if (out_free) st_reg <= IDLE;
                end
                default: st_reg <= IDLE;
            endcase
        end
    end
endmodule
